// ----- hdl/lcs_pkg.sv -----
// shared types, sizes and codes for the longest common subsequence engine
// no dependencies
`default_nettype none

package lcs_pkg;

  localparam int MAX_LEN   = 16;
  localparam int TABLE_DIM = MAX_LEN + 1;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TBL_DEPTH = TABLE_DIM * TABLE_DIM;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int SYM_W     = 8;
  localparam int CLEN_W    = 5;

  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SYM_W-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0]  out_symbol;
    logic              has_symbol;
    logic [CLEN_W-1:0] common_length;
    logic              overflow;
    logic              last;
  } out_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LEN_W-1:0] row,
                                                 input logic [LEN_W-1:0] col);
    tbl_addr = TBL_AW'(row) * TBL_AW'(TABLE_DIM) + TBL_AW'(col);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/longest_common_subsequence_top.sv -----
// longest common subsequence engine: loads are taken while idle, a run fills
// the length table by a read and a write state per cell (m*n cells), traces
// back via read states and a decide state per step (at most m+n steps), then
// emits results via read and load states; one item is in work at a time
// synchronous reset empties both strings and clears the overflow flag
// depends on lcs_pkg and lcs_ram
`default_nettype none

module longest_common_subsequence_top
  import lcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_CWR  = 4'd2;
  localparam logic [3:0] S_TTOT = 4'd3;
  localparam logic [3:0] S_TTW  = 4'd4;
  localparam logic [3:0] S_TRD1 = 4'd5;
  localparam logic [3:0] S_TRD2 = 4'd6;
  localparam logic [3:0] S_TDEC = 4'd7;
  localparam logic [3:0] S_ERD  = 4'd8;
  localparam logic [3:0] S_ELD  = 4'd9;

  logic [3:0]       state;
  logic [LEN_W-1:0] flen;
  logic [LEN_W-1:0] slen;
  logic             ovf;
  logic [LEN_W-1:0] i;
  logic [LEN_W-1:0] j;
  logic [LEN_W-1:0] diag;
  logic [LEN_W-1:0] left;
  logic [LEN_W-1:0] up;
  logic [LEN_W-1:0] total;
  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] k;

  logic [IDX_W-1:0]  a_waddr, a_raddr, b_waddr, b_raddr, r_waddr, r_raddr;
  logic              a_we, b_we, r_we, t_we;
  logic [SYM_W-1:0]  a_rdata, b_rdata, r_rdata;
  logic [TBL_AW-1:0] t_waddr, t_raddr;
  logic [LEN_W-1:0]  t_wdata, t_rdata;

  logic [LEN_W-1:0] im1, jm1, pm1;
  logic [LEN_W-1:0] up_c, left_c, v_c;
  logic [LEN_W-1:0] i_dec, j_dec;
  logic             sym_eq;
  logic             take;
  logic             load_out;
  logic             accept;

  assign im1    = i - LEN_W'(1);
  assign jm1    = j - LEN_W'(1);
  assign pm1    = pos - LEN_W'(1);
  assign sym_eq = (a_rdata == b_rdata);
  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  assign up_c   = (i == LEN_W'(1)) ? '0 : t_rdata;
  assign left_c = (j == LEN_W'(1)) ? '0 : t_rdata;
  assign v_c    = sym_eq ? diag + LEN_W'(1) : ((up_c > left) ? up_c : left);
  assign take   = sym_eq || (up > left_c);
  assign i_dec  = take ? im1 : i;
  assign j_dec  = (sym_eq || !(up > left_c)) ? jm1 : j;

  assign load_out = (state == S_ELD) && (!out_valid || out_ready);

  // string and buffer ports
  assign a_we    = accept && in_data.mode == MODE_FIRST && flen != LEN_W'(MAX_LEN);
  assign b_we    = accept && in_data.mode == MODE_SECOND && slen != LEN_W'(MAX_LEN);
  assign a_waddr = flen[IDX_W-1:0];
  assign b_waddr = slen[IDX_W-1:0];
  assign a_raddr = im1[IDX_W-1:0];
  assign b_raddr = jm1[IDX_W-1:0];
  assign r_we    = (state == S_TDEC) && sym_eq && pos != '0;
  assign r_waddr = pm1[IDX_W-1:0];
  assign r_raddr = k[IDX_W-1:0];

  // table ports
  assign t_we    = (state == S_CWR);
  assign t_waddr = tbl_addr(i, j);
  assign t_wdata = v_c;

  always_comb begin
    case (state)
      S_TTOT:  t_raddr = tbl_addr(i, j);
      S_TRD2:  t_raddr = tbl_addr(i, jm1);
      default: t_raddr = tbl_addr(im1, j);
    endcase
  end

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_data.symbol),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_data.symbol),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  lcs_ram #(.WIDTH(LEN_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_result (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(a_rdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flen      <= '0;
      slen      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.mode)
              MODE_FIRST: begin
                if (flen == LEN_W'(MAX_LEN)) ovf <= 1'b1;
                else flen <= flen + LEN_W'(1);
              end
              MODE_SECOND: begin
                if (slen == LEN_W'(MAX_LEN)) ovf <= 1'b1;
                else slen <= slen + LEN_W'(1);
              end
              MODE_RUN: begin
                k <= '0;
                if (flen == '0 || slen == '0) begin
                  total <= '0;
                  state <= S_ELD;
                end else begin
                  i     <= LEN_W'(1);
                  j     <= LEN_W'(1);
                  diag  <= '0;
                  left  <= '0;
                  state <= S_CRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_CRD: state <= S_CWR;
        S_CWR: begin
          if (j == slen) begin
            if (i == flen) begin
              state <= S_TTOT;
            end else begin
              i     <= i + LEN_W'(1);
              j     <= LEN_W'(1);
              diag  <= '0;
              left  <= '0;
              state <= S_CRD;
            end
          end else begin
            diag  <= up_c;
            left  <= v_c;
            j     <= j + LEN_W'(1);
            state <= S_CRD;
          end
        end
        S_TTOT: state <= S_TTW;
        S_TTW: begin
          total <= t_rdata;
          pos   <= t_rdata;
          state <= S_TRD1;
        end
        S_TRD1: state <= S_TRD2;
        S_TRD2: begin
          up    <= up_c;
          state <= S_TDEC;
        end
        S_TDEC: begin
          if (sym_eq && pos != '0) pos <= pm1;
          i <= i_dec;
          j <= j_dec;
          if (i_dec == '0 || j_dec == '0) begin
            state <= (total == '0) ? S_ELD : S_ERD;
          end else begin
            state <= S_TRD1;
          end
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          if (load_out) begin
            out_valid <= 1'b1;
            if (total == '0 || k == total - LEN_W'(1)) begin
              flen  <= '0;
              slen  <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              k     <= k + LEN_W'(1);
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.out_symbol    <= (total == '0) ? '0 : r_rdata;
      out_data.has_symbol    <= (total != '0);
      out_data.common_length <= CLEN_W'(total);
      out_data.overflow      <= ovf;
      out_data.last          <= (total == '0) || (k == total - LEN_W'(1));
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lcs_ram.sv -----
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- test/tb_longest_common_subsequence_top.sv -----
// testbench for longest_common_subsequence_top: loads random and directed string pairs,
// runs the engine and checks every emitted subsequence symbol against an in-bench predictor
// depends on lcs_pkg and the longest_common_subsequence_top rtl
module tb_longest_common_subsequence_top;
  import lcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 12;
  localparam int RANDOM_ITEMS = 430;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  class lcs_tracker;
    logic [SYM_W-1:0] first_syms [MAX_LEN];
    logic [SYM_W-1:0] second_syms [MAX_LEN];
    int first_count;
    int second_count;
    bit dropped;
    out_t pending_symbols[$];
    int mismatches;
    int results_checked;
    int runs;
    int overflow_runs;
    int longest;

    function void note_transfer(in_t item);
      case (item.mode)
        MODE_FIRST: begin
          if (first_count >= MAX_LEN) begin
            dropped = 1'b1;
          end else begin
            first_syms[first_count] = item.symbol;
            first_count++;
          end
        end
        MODE_SECOND: begin
          if (second_count >= MAX_LEN) begin
            dropped = 1'b1;
          end else begin
            second_syms[second_count] = item.symbol;
            second_count++;
          end
        end
        MODE_RUN: solve_subsequence();
        default: ;
      endcase
    endfunction

    function void solve_subsequence();
      int lengths [TABLE_DIM][TABLE_DIM];
      logic [SYM_W-1:0] picked [MAX_LEN];
      int i;
      int j;
      int total;
      int pos;
      out_t r;
      for (i = 0; i <= first_count; i++) begin
        for (j = 0; j <= second_count; j++) begin
          if (i == 0 || j == 0) begin
            lengths[i][j] = 0;
          end else if (first_syms[i-1] == second_syms[j-1]) begin
            lengths[i][j] = lengths[i-1][j-1] + 1;
          end else begin
            lengths[i][j] = (lengths[i-1][j] > lengths[i][j-1]) ? lengths[i-1][j] : lengths[i][j-1];
          end
        end
      end
      total = lengths[first_count][second_count];
      pos = total;
      i = first_count;
      j = second_count;
      // walk back from the far corner, ties step the second index
      while (i > 0 && j > 0) begin
        if (first_syms[i-1] == second_syms[j-1]) begin
          if (pos > 0) begin
            pos--;
            picked[pos] = first_syms[i-1];
          end
          i--;
          j--;
        end else if (lengths[i-1][j] > lengths[i][j-1]) begin
          i--;
        end else begin
          j--;
        end
      end
      if (total == 0) begin
        r = '0;
        r.overflow = dropped;
        r.last = 1'b1;
        pending_symbols.push_back(r);
      end else begin
        for (int k = 0; k < total; k++) begin
          r = '0;
          r.out_symbol = picked[k];
          r.has_symbol = 1'b1;
          r.common_length = CLEN_W'(total);
          r.overflow = dropped;
          r.last = (k + 1 == total);
          pending_symbols.push_back(r);
        end
      end
      runs++;
      if (dropped) overflow_runs++;
      if (total > longest) longest = total;
      first_count = 0;
      second_count = 0;
      dropped = 1'b0;
    endfunction

    function void check_transfer(out_t got);
      out_t want;
      results_checked++;
      if (pending_symbols.size() == 0) begin
        $error("result transfer with nothing expected: %p", got);
        mismatches++;
        return;
      end
      want = pending_symbols.pop_front();
      if (got.out_symbol !== want.out_symbol) begin
        $error("out_symbol: expected %0d, got %0d", want.out_symbol, got.out_symbol);
        mismatches++;
      end
      if (got.has_symbol !== want.has_symbol) begin
        $error("has_symbol: expected %0d, got %0d", want.has_symbol, got.has_symbol);
        mismatches++;
      end
      if (got.common_length !== want.common_length) begin
        $error("common_length: expected %0d, got %0d", want.common_length, got.common_length);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  lcs_tracker tracker;
  int items_sent = 0;
  int ignored_sent = 0;
  int idle_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  longest_common_subsequence_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  task automatic send_item(input logic [1:0] mode, input logic [SYM_W-1:0] symbol);
    in_t item;
    int gap;
    item.mode = mode;
    item.symbol = symbol;
    gap = (items_sent >= 200 && items_sent < 260) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    tracker.note_transfer(item);
    if (mode == MODE_UNUSED) ignored_sent++;
    else items_sent++;
  endtask

  task automatic load_and_run(input int first_n, input int second_n, input int alphabet);
    int left_a;
    int left_b;
    int base;
    logic [SYM_W-1:0] sym;
    left_a = first_n;
    left_b = second_n;
    base = $urandom_range(0, 256 - alphabet);
    while (left_a > 0 || left_b > 0) begin
      sym = SYM_W'(base + $urandom_range(0, alphabet - 1));
      if ($urandom_range(0, 24) == 0) send_item(MODE_UNUSED, SYM_W'($urandom));
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 1)) begin
        send_item(MODE_FIRST, sym);
        left_a--;
      end else begin
        send_item(MODE_SECOND, sym);
        left_b--;
      end
    end
    send_item(MODE_RUN, SYM_W'($urandom));
  endtask

  // receiver: random ready gaps, a calm band, and one long hold-off
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && tracker.results_checked >= HOLD_AT) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end else if (tracker.results_checked >= 80 && tracker.results_checked < 140) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 14);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_transfer(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** longest_common_subsequence_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int seq;
    int pick;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty strings, ignored mode, extreme symbols, no match, full match
    send_item(MODE_RUN, 8'hFF);
    send_item(MODE_UNUSED, 8'hFF);
    send_item(MODE_UNUSED, 8'h00);
    send_item(MODE_FIRST, 8'h00);
    send_item(MODE_FIRST, 8'hFF);
    send_item(MODE_SECOND, 8'hFF);
    send_item(MODE_SECOND, 8'h00);
    send_item(MODE_RUN, 8'h00);
    send_item(MODE_FIRST, 8'h55);
    send_item(MODE_SECOND, 8'hAA);
    send_item(MODE_RUN, 8'h55);
    send_item(MODE_FIRST, 8'h41);
    send_item(MODE_SECOND, 8'h41);
    send_item(MODE_FIRST, 8'h42);
    send_item(MODE_SECOND, 8'h42);
    send_item(MODE_FIRST, 8'h43);
    send_item(MODE_SECOND, 8'h43);
    send_item(MODE_RUN, 8'hAA);

    seq = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (seq == 0) begin
        load_and_run(MAX_LEN, MAX_LEN, 1);
      end else if (seq == 1) begin
        load_and_run(MAX_LEN + 2, MAX_LEN + 1, 4);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          load_and_run($urandom_range(12, MAX_LEN + 2), $urandom_range(12, MAX_LEN + 2),
                       $urandom_range(1, 256));
        end else if (pick == 1) begin
          repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(0, 3)), SYM_W'($urandom));
        end else if (pick < 6) begin
          load_and_run($urandom_range(0, 8), $urandom_range(0, 8), 256);
        end else begin
          load_and_run($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(2, 6));
        end
      end
      seq++;
    end
    in_valid <= 1'b0;

    while (tracker.pending_symbols.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d loads and runs plus %0d ignored items sent, %0d results checked over %0d runs",
             items_sent, ignored_sent, tracker.results_checked, tracker.runs);
    $display("%0d runs had dropped symbols, longest common subsequence %0d",
             tracker.overflow_runs, tracker.longest);
    if (tracker.mismatches == 0) begin
      $display("** longest_common_subsequence_top: PASSED **");
    end else begin
      $display("** longest_common_subsequence_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- longest_common_subsequence_top.f -----
hdl/lcs_pkg.sv
hdl/lcs_ram.sv
hdl/longest_common_subsequence_top.sv
test/tb_longest_common_subsequence_top.sv
